// ===== hdl/d2csr_pkg.sv =====
// shared types, constants and helper functions for the dense to csr compressor
package d2csr_pkg;

   localparam logic [31:0] F32_INF  = 32'h7F80_0000;
   localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
   localparam logic [30:0] KEPT_MAX = 31'h7FFF_FFFF;
   localparam logic [16:0] DIM_MAX  = 17'd65536;

   localparam logic [1:0] FMT_F32  = 2'd0;
   localparam logic [1:0] FMT_F16  = 2'd1;
   localparam logic [1:0] FMT_BF16 = 2'd2;
   localparam logic [1:0] FMT_C64  = 2'd3;

   localparam logic [7:0] CSR_FORMAT    = 8'd0;
   localparam logic [7:0] CSR_THRESHOLD = 8'd1;
   localparam logic [7:0] CSR_COLUMNS   = 8'd2;
   localparam logic [7:0] CSR_ROWS      = 8'd3;

   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_ROWEND = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [63:0] entry_value;
      logic [15:0] column;
      logic [30:0] row_pointer;
      logic        overflow;
      logic        last_of_run;
      logic        matrix_done;
   } rsp_type;

   // exact widening of a half magnitude to single bits
   function automatic logic [31:0] half_abs_to_single(input logic [14:0] h);
      logic [4:0] ex;
      logic [9:0] m;
      logic [3:0] p;
      logic [3:0] sh;
      logic [19:0] ms;
      logic [7:0] e;
      ex = h[14:10];
      m  = h[9:0];
      p  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) p = 4'(i);
      end
      sh = 4'd10 - p;
      ms = {10'd0, m} << sh;
      e  = 8'd113 - {4'd0, sh};
      if (ex == 5'd31) begin
         half_abs_to_single = F32_INF | {9'd0, m, 13'd0};
      end else if (ex != 5'd0) begin
         half_abs_to_single = {1'b0, {3'd0, ex} + 8'd112, m, 13'd0};
      end else if (m == 10'd0) begin
         half_abs_to_single = 32'd0;
      end else begin
         half_abs_to_single = {1'b0, e, ms[9:0], 13'd0};
      end
   endfunction

   function automatic logic single_above(input logic [31:0] a, input logic [31:0] t);
      single_above = (a <= F32_INF) && (t <= F32_INF) && (a > t);
   endfunction

   function automatic logic [16:0] eff_count(input logic [16:0] r);
      if (r == 17'd0) begin
         eff_count = 17'd1;
      end else if (r > DIM_MAX) begin
         eff_count = DIM_MAX;
      end else begin
         eff_count = r;
      end
   endfunction

endpackage

// ===== hdl/d2csr_keep.sv =====
// four stage keep test, exact complex magnitude compare
module d2csr_keep (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] value_bits,
   input  logic [1:0]  value_format,
   input  logic [30:0] threshold_bits,
   output logic        kept
);

   logic [31:0] lo, hi, ra, ia, a, b, t;
   logic        tz;
   logic        dec_c, dk_c;
   logic [7:0]  ea, eb, et, dtb;
   logic [23:0] ma, mb, mt;
   logic [24:0] tv, av;

   logic        dec2_ff, dk2_ff;
   logic [24:0] t2_ff, a2_ff;
   logic [23:0] b2_ff;
   logic [5:0]  k2_ff;

   logic        dec3_ff, dk3_ff;
   logic [49:0] tsq3_ff, asq3_ff;
   logic [47:0] bsq3_ff;
   logic [5:0]  k3_ff;

   logic        dec4_ff, dk4_ff;
   logic [49:0] d4_ff;
   logic [47:0] bsq4_ff;
   logic [5:0]  k4_ff;

   logic [99:0] rhs, lhs;

   always_comb begin
      lo  = value_bits[31:0];
      hi  = value_bits[63:32];
      ra  = lo & d2csr_pkg::ABS_MASK;
      ia  = hi & d2csr_pkg::ABS_MASK;
      t   = {1'b0, threshold_bits};
      tz  = (threshold_bits == 31'd0);
      a   = (ra >= ia) ? ra : ia;
      b   = (ra >= ia) ? ia : ra;
      ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      et  = (t[30:23] == 8'd0) ? 8'd1 : t[30:23];
      ma  = {a[30:23] != 8'd0, a[22:0]};
      mb  = {b[30:23] != 8'd0, b[22:0]};
      mt  = {t[30:23] != 8'd0, t[22:0]};
      dtb = et - eb;
      tv  = {mt, 1'b0};
      av  = (ea == et) ? {ma, 1'b0} : {1'b0, ma};
      dec_c = 1'b1;
      dk_c  = 1'b0;
      case (value_format)
         d2csr_pkg::FMT_F32: begin
            dk_c = tz ? (ra != 32'd0) : d2csr_pkg::single_above(ra, t);
         end
         d2csr_pkg::FMT_F16: begin
            dk_c = tz ? (lo[14:0] != 15'd0)
                      : d2csr_pkg::single_above(d2csr_pkg::half_abs_to_single(lo[14:0]), t);
         end
         d2csr_pkg::FMT_BF16: begin
            dk_c = tz ? (lo[14:0] != 15'd0)
                      : d2csr_pkg::single_above({1'b0, lo[14:0], 16'd0}, t);
         end
         d2csr_pkg::FMT_C64: begin
            if (tz) begin
               dk_c = (ra != 32'd0) || (ia != 32'd0);
            end else if (t > d2csr_pkg::F32_INF) begin
               dk_c = 1'b0;
            end else if (ra == d2csr_pkg::F32_INF || ia == d2csr_pkg::F32_INF) begin
               dk_c = (t < d2csr_pkg::F32_INF);
            end else if (ra > d2csr_pkg::F32_INF || ia > d2csr_pkg::F32_INF
                         || t == d2csr_pkg::F32_INF) begin
               dk_c = 1'b0;
            end else if (a > t) begin
               dk_c = 1'b1;
            end else if (a == t) begin
               dk_c = (b != 32'd0);
            end else if (({1'b0, ea} + 9'd1) < {1'b0, et}) begin
               dk_c = 1'b0;
            end else if (dtb >= 8'd25) begin
               dk_c = 1'b0;
            end else begin
               dec_c = 1'b0;
            end
         end
         default: begin
            dk_c = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec2_ff <= dec_c;
         dk2_ff  <= dk_c;
         t2_ff   <= tv;
         a2_ff   <= av;
         b2_ff   <= mb;
         k2_ff   <= {dtb[4:0], 1'b0};

         dec3_ff <= dec2_ff;
         dk3_ff  <= dk2_ff;
         tsq3_ff <= t2_ff * t2_ff;
         asq3_ff <= a2_ff * a2_ff;
         bsq3_ff <= b2_ff * b2_ff;
         k3_ff   <= k2_ff;

         dec4_ff <= dec3_ff;
         dk4_ff  <= dk3_ff;
         d4_ff   <= tsq3_ff - asq3_ff;
         bsq4_ff <= bsq3_ff;
         k4_ff   <= k3_ff;
      end
   end

   always_comb begin
      rhs  = {50'd0, d4_ff} << k4_ff;
      lhs  = {50'd0, bsq4_ff, 2'b00};
      kept = dec4_ff ? dk4_ff : (lhs > rhs);
   end

endmodule

// ===== hdl/dense_to_csr_compressor_core.sv =====
// dense to csr compressor top level: request pipeline, counters and result queue
//
// Dense matrix elements enter on the req_ channel in row-major order, one per
// request. Each request gives a kept-entry result when the element passes the
// keep test, and a row-end result with the running count on the last column.
// Results leave on the rsp_ channel; csr_ writes the format, threshold and
// matrix size registers and should only be used while the block is idle.
// A request passes through an input register and three stages of the complex
// magnitude compare into the result register. One request is accepted per
// cycle while the output is not stalled; a request that yields two results
// holds the pipeline while the second result drains.
// Reset clears all counters, the overflow flag and the pipeline valids, and
// restores the register defaults. When rsp_ready is low and a result is held,
// the result register holds and the whole pipeline stalls, dropping req_ready,
// whenever a request waits in the last stage.
module dense_to_csr_compressor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [63:0] rsp_entry_value,
   output logic [15:0] rsp_column,
   output logic [30:0] rsp_row_pointer,
   output logic        rsp_overflow,
   output logic        rsp_last_of_run,
   output logic        rsp_matrix_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0]  fmt_ff;
   logic [30:0] thr_ff;
   logic [16:0] cols_ff, rows_ff;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [63:0] s1_bits_ff, s2_bits_ff, s3_bits_ff, s4_bits_ff;

   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [30:0] total_ff, total_in;
   logic        ovf_ff, ovf_in;

   logic        out_valid_ff, pend2_ff;
   d2csr_pkg::rsp_type head_ff, second_ff, entry_r, rowend_r;

   logic        advance, efree, kept, load;
   logic        row_end, mat_end;
   logic [16:0] cols_eff, rows_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= d2csr_pkg::FMT_F32;
         thr_ff  <= 31'd0;
         cols_ff <= 17'd1;
         rows_ff <= 17'd1;
      end else if (csr_valid) begin
         case (csr_index)
            d2csr_pkg::CSR_FORMAT:    fmt_ff  <= csr_data[1:0];
            d2csr_pkg::CSR_THRESHOLD: thr_ff  <= csr_data[30:0];
            d2csr_pkg::CSR_COLUMNS:   cols_ff <= csr_data[16:0];
            d2csr_pkg::CSR_ROWS:      rows_ff <= csr_data[16:0];
            default: begin
            end
         endcase
      end
   end

   assign efree     = !out_valid_ff || (rsp_ready && !pend2_ff);
   assign advance   = !s4_valid_ff || efree;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_bits_ff <= req_value_bits;
         s2_bits_ff <= s1_bits_ff;
         s3_bits_ff <= s2_bits_ff;
         s4_bits_ff <= s3_bits_ff;
      end
   end

   d2csr_keep u_keep (
      .clock          (clock),
      .advance        (advance),
      .value_bits     (s1_bits_ff),
      .value_format   (fmt_ff),
      .threshold_bits (thr_ff),
      .kept           (kept)
   );

   always_comb begin
      cols_eff = d2csr_pkg::eff_count(cols_ff);
      rows_eff = d2csr_pkg::eff_count(rows_ff);
      row_end  = ({1'b0, col_ff} + 17'd1) >= cols_eff;
      mat_end  = row_end && (({1'b0, row_ff} + 17'd1) >= rows_eff);
      load     = advance && s4_valid_ff;

      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (kept) begin
         if (total_ff == d2csr_pkg::KEPT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            total_in = total_ff + 31'd1;
         end
      end

      entry_r.kind        = d2csr_pkg::KIND_ENTRY;
      entry_r.entry_value = s4_bits_ff;
      entry_r.column      = col_ff;
      entry_r.row_pointer = 31'd0;
      entry_r.overflow    = ovf_in;
      entry_r.last_of_run = !row_end;
      entry_r.matrix_done = 1'b0;

      rowend_r.kind        = d2csr_pkg::KIND_ROWEND;
      rowend_r.entry_value = 64'd0;
      rowend_r.column      = 16'd0;
      rowend_r.row_pointer = total_in;
      rowend_r.overflow    = ovf_in;
      rowend_r.last_of_run = 1'b1;
      rowend_r.matrix_done = mat_end;

      col_in = col_ff + 16'd1;
      row_in = row_ff;
      if (row_end) begin
         col_in = 16'd0;
         if (mat_end) begin
            row_in   = 16'd0;
            total_in = 31'd0;
         end else begin
            row_in = row_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 16'd0;
         row_ff   <= 16'd0;
         total_ff <= 31'd0;
         ovf_ff   <= 1'b0;
      end else if (load) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend2_ff     <= 1'b0;
      end else if (load && (kept || row_end)) begin
         out_valid_ff <= 1'b1;
         pend2_ff     <= kept && row_end;
      end else if (out_valid_ff && rsp_ready) begin
         if (pend2_ff) begin
            pend2_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && (kept || row_end)) begin
         head_ff   <= kept ? entry_r : rowend_r;
         second_ff <= rowend_r;
      end else if (out_valid_ff && rsp_ready && pend2_ff) begin
         head_ff <= second_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = head_ff.kind;
   assign rsp_entry_value = head_ff.entry_value;
   assign rsp_column      = head_ff.column;
   assign rsp_row_pointer = head_ff.row_pointer;
   assign rsp_overflow    = head_ff.overflow;
   assign rsp_last_of_run = head_ff.last_of_run;
   assign rsp_matrix_done = head_ff.matrix_done;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the dense to csr compressor: directed table, random stream, predictor check
module tb_top;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_value_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [63:0] rsp_entry_value;
   logic [15:0] rsp_column;
   logic [30:0] rsp_row_pointer;
   logic        rsp_overflow;
   logic        rsp_last_of_run;
   logic        rsp_matrix_done;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   dense_to_csr_compressor_core u_top (.*);

   typedef struct {
      logic [63:0] bits;
      logic        has_exp;
      logic        e_kind;
      logic        e_last;
   } stim_row_type;

   // predictor state
   logic [1:0]  m_fmt;
   logic [30:0] m_thr;
   logic [16:0] m_cols;
   logic [16:0] m_rows;
   logic [15:0] m_col;
   logic [15:0] m_row;
   logic [30:0] m_kept;
   logic        m_ovf;

   d2csr_pkg::rsp_type expected_rsps[$];
   int          mismatches;
   int          idle_cycles;
   logic        timed_out;
   int          rsp_wait;
   int          rsp_draw;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] widen_half(logic [14:0] h);
      logic [31:0] m;
      logic [7:0]  e;
      if (h[14:10] == 5'd31) return 32'h7F80_0000 | {9'd0, h[9:0], 13'd0};
      if (h[14:10] != 5'd0) return {1'b0, 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
      if (h[9:0] == 10'd0) return 32'd0;
      m = {22'd0, h[9:0]};
      e = 8'd113;
      while (m[10] == 1'b0) begin
         m = m << 1;
         e = e - 8'd1;
      end
      return {1'b0, e, m[9:0], 13'd0};
   endfunction

   function automatic logic gt_f32(logic [31:0] a, logic [31:0] t);
      return a <= 32'h7F80_0000 && t <= 32'h7F80_0000 && a > t;
   endfunction

   // exact square scaled by 2^298
   function automatic logic [639:0] square_scaled(logic [31:0] a);
      logic [639:0] m;
      int           base;
      m = {616'd0, 1'b0, a[22:0]};
      base = 0;
      if (a[30:23] != 8'd0) begin
         m[23] = 1'b1;
         base = 2 * (int'(a[30:23]) - 1);
      end
      return (m * m) << base;
   endfunction

   function automatic logic keeps(logic [63:0] b);
      logic [31:0] lo, hi, t;
      lo = {1'b0, b[30:0]};
      hi = {1'b0, b[62:32]};
      t = {1'b0, m_thr};
      if (t == 0) begin
         case (m_fmt)
            d2csr_pkg::FMT_F32: return lo != 0;
            d2csr_pkg::FMT_C64: return lo != 0 || hi != 0;
            default: return b[14:0] != 0;
         endcase
      end
      case (m_fmt)
         d2csr_pkg::FMT_F32:  return gt_f32(lo, t);
         d2csr_pkg::FMT_F16:  return gt_f32(widen_half(b[14:0]), t);
         d2csr_pkg::FMT_BF16: return gt_f32({1'b0, b[14:0], 16'd0}, t);
         default: begin
            if (t > 32'h7F80_0000) return 1'b0;
            if (lo == 32'h7F80_0000 || hi == 32'h7F80_0000) return t < 32'h7F80_0000;
            if (lo > 32'h7F80_0000 || hi > 32'h7F80_0000 || t == 32'h7F80_0000)
               return 1'b0;
            return (square_scaled(lo) + square_scaled(hi)) > square_scaled(t);
         end
      endcase
   endfunction

   function automatic logic [16:0] clip_dim(logic [16:0] r);
      if (r == 0) return 17'd1;
      if (r > 17'd65536) return 17'd65536;
      return r;
   endfunction

   function automatic int predict_element(logic [63:0] b);
      d2csr_pkg::rsp_type r;
      logic    k, re, me;
      int      n;
      n = 0;
      k = keeps(b);
      re = {1'b0, m_col} + 17'd1 >= clip_dim(m_cols);
      me = re && ({1'b0, m_row} + 17'd1 >= clip_dim(m_rows));
      if (k) begin
         if (m_kept == d2csr_pkg::KEPT_MAX) m_ovf = 1'b1;
         else m_kept = m_kept + 31'd1;
         r = '{d2csr_pkg::KIND_ENTRY, b, m_col, 31'd0, m_ovf, !re, 1'b0};
         expected_rsps = {expected_rsps, r};
         n++;
      end
      if (re) begin
         r = '{d2csr_pkg::KIND_ROWEND, 64'd0, 16'd0, m_kept, m_ovf, 1'b1, me};
         expected_rsps = {expected_rsps, r};
         n++;
         m_col = 0;
         if (me) begin
            m_row = 0;
            m_kept = 0;
         end else m_row = m_row + 16'd1;
      end else m_col = m_col + 16'd1;
      return n;
   endfunction

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         d2csr_pkg::CSR_FORMAT:    m_fmt = val[1:0];
         d2csr_pkg::CSR_THRESHOLD: m_thr = val[30:0];
         d2csr_pkg::CSR_COLUMNS:   m_cols = val[16:0];
         d2csr_pkg::CSR_ROWS:      m_rows = val[16:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0 && !timed_out) @(posedge clock);
      wait_cycles(12);
   endtask

   task automatic send_request(logic [63:0] b);
      int gap;
      gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 9)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         wait_cycles(gap);
      end
      req_valid <= 1'b1;
      req_value_bits <= b;
      do @(posedge clock); while (!req_ready);
      void'(predict_element(b));
   endtask

   task automatic setup(logic [1:0] f, logic [31:0] t, logic [31:0] c, logic [31:0] r);
      drain();
      write_reg(d2csr_pkg::CSR_FORMAT, {30'd0, f});
      write_reg(d2csr_pkg::CSR_THRESHOLD, t);
      write_reg(d2csr_pkg::CSR_COLUMNS, c);
      write_reg(d2csr_pkg::CSR_ROWS, r);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      int          s;
      v = {$urandom, $urandom};
      s = $urandom_range(0, 9);
      case (s)
         0: v = v & 64'hFFFF_FFFF_8000_0000;
         1: v = v & 64'h8000_0000_8000_0000;
         2: v[30:23] = 8'hFF;
         3: v[14:0] = v[14] ? 15'h7C00 : 15'h0;
         4: v[62:55] = 8'hFF;
         5: v[30:0] = 31'({$urandom} % 32'h0100_0000);
         default: ;
      endcase
      if (m_fmt != d2csr_pkg::FMT_C64 && $urandom_range(0, 3) != 0) v[63:32] = '0;
      return v;
   endfunction

   stim_row_type directed[$];

   initial begin
      stim_row_type sr;
      logic [31:0] thr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value_bits = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      m_fmt = d2csr_pkg::FMT_F32; m_thr = 0; m_cols = 1; m_rows = 1;
      m_col = 0; m_row = 0; m_kept = 0; m_ovf = 0;
      wait_cycles(4);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: 1x1 matrix, float32, zero threshold
      directed = '{
         '{64'h0, 1'b1, d2csr_pkg::KIND_ROWEND, 1'b1},
         '{64'h8000_0000, 1'b1, d2csr_pkg::KIND_ROWEND, 1'b1},
         '{64'hFFFF_FFFF_0000_0000, 1'b1, d2csr_pkg::KIND_ROWEND, 1'b1},
         '{64'h7FC0_0000, 1'b0, 1'b0, 1'b0},
         '{64'h0000_0001, 1'b0, 1'b0, 1'b0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}
      };
      foreach (directed[i]) begin
         sr = directed[i];
         if (sr.has_exp) begin
            drain();
            send_request(sr.bits);
            if (expected_rsps.size() != 1 || expected_rsps[0].kind != sr.e_kind
                || expected_rsps[0].last_of_run != sr.e_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("directed row %0d exp kind=%0d last=%0d act count=%0d",
                           i, sr.e_kind, sr.e_last, expected_rsps.size());
            end
         end else send_request(sr.bits);
      end
      setup(d2csr_pkg::FMT_C64, 32'h3F80_0000, 3, 2);
      foreach (directed[i]) send_request(directed[i].bits);
      send_request(64'h3F80_0000_0000_0000);
      send_request(64'h7FC0_0000_7F80_0000);
      send_request(64'h3F35_04F3_3F35_04F3);
      setup(d2csr_pkg::FMT_F16, 32'h7F80_0000, 0, 0);
      send_request(64'h7C00);
      setup(d2csr_pkg::FMT_F16, 32'h3800_0000, 32'h1FFFF, 2);
      send_request(64'h0001);
      send_request(64'h7BFF);
      send_request(64'hFFFF);
      setup(d2csr_pkg::FMT_BF16, 32'h7FC0_0000, 4, 1);
      send_request(64'h7F80);
      setup(d2csr_pkg::FMT_F32, 32'h7FFF_FFFF, 5, 3);
      send_request(64'h7F80_0000);

      for (int ph = 0; ph < 8; ph++) begin
         thr = ($urandom_range(0, 2) == 0) ? 0 : {$urandom} % 32'h7F80_0001;
         if (ph == 3) thr = 32'h7F80_0000;
         if (ph == 5) thr = 32'h0000_0001;
         setup(2'(ph), thr, $urandom_range(1, 7), (ph == 7) ? 65536 : $urandom_range(1, 4));
         for (int i = 0; i < 50; i++) begin
            if (i == 25) drain();
            send_request(rand_value());
         end
      end
      drain();
      if (mismatches == 0 && !timed_out) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // response side: per-response wait and comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response exp=none act kind=%0d", rsp_kind);
            end else begin
               if ({rsp_kind, rsp_entry_value, rsp_column, rsp_row_pointer, rsp_overflow,
                    rsp_last_of_run, rsp_matrix_done} != expected_rsps[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp=%h act=%h", expected_rsps[0],
                              {rsp_kind, rsp_entry_value, rsp_column, rsp_row_pointer,
                               rsp_overflow, rsp_last_of_run, rsp_matrix_done});
               end
               void'(expected_rsps.pop_front());
            end
            rsp_draw = $urandom_range(0, 9);
            rsp_wait <= rsp_draw;
            rsp_ready <= (rsp_draw == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ready <= (rsp_wait == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         timed_out = 1'b1;
         $display("Regression FAIL");
         $finish;
      end
   end

   initial timed_out = 1'b0;
   initial mismatches = 0;
   initial idle_cycles = 0;

endmodule
